[rtl/glbp_pkg.sv]
// Shared types and constants of the greedy load balanced placer.
`timescale 1ns / 1ps
package glbp_pkg;

  localparam int CLASSES      = 2;     // class 0 is dense, class 1 is sparse
  localparam int GROUPS       = 4;     // groups in each class
  localparam int GRP_W        = 2;
  localparam int VID_W        = 24;
  localparam int COST_W       = 24;
  localparam int PLACED_W     = 24;
  localparam int EDGE_W       = 48;
  localparam int NUM_W        = 49;    // edge sum plus one cost
  localparam int RATE_W       = 32;
  localparam int CAP_W        = 16;
  localparam int PCOUNT_W     = 9;
  localparam int PIPES_W      = 64;
  localparam int PIPE_W       = 8;
  localparam int TP_W         = 40;    // rate times pipelines
  localparam int CTP_W        = 42;    // sum of the group throughputs of a class
  localparam int ROOM_W       = 25;
  localparam int PROD_W       = 91;
  localparam int PART_W       = 8;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int IN_DATA_W    = 48;
  localparam int OUT_DATA_W   = 40;
  localparam int DIV_CNT_W    = 5;
  localparam int DIV_STEPS    = 24;
  localparam int PROD_SLOTS   = 4;
  localparam int SLOT_W       = 2;

  localparam logic [PCOUNT_W-1:0] PCOUNT_MAX = 9'd256;
  localparam logic [TP_W-1:0]     TP_FLOOR   = 40'd256;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_DENSE_RATE   = 3'd0,
    CFG_SPARSE_RATE  = 3'd1,
    CFG_DENSE_CAP    = 3'd2,
    CFG_SPARSE_CAP   = 3'd3,
    CFG_PART_COUNT   = 3'd4,
    CFG_DENSE_PIPES  = 3'd5,
    CFG_SPARSE_PIPES = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MS_NUM_BTP  = 3'd0,   // candidate numerator times best throughput
    MS_BNUM_TP  = 3'd1,   // best numerator times candidate throughput
    MS_DEC_ST   = 3'd2,   // (dense total + cost) times sparse class throughput
    MS_SE_DT    = 3'd3,   // sparse total times dense class throughput
    MS_DE_ST    = 3'd4,   // dense total times sparse class throughput
    MS_SEC_DT   = 3'd5    // (sparse total + cost) times dense class throughput
  } mul_sel_t;

  typedef struct packed {
    logic              start_item;
    logic              cls;
    logic [GRP_W-1:0]  g;
    logic              use_pick;
    logic              acc_tp;
    logic              take;
    logic              mul_start;
    mul_sel_t          mul_sel;
    logic              prod_wr;
    logic [SLOT_W-1:0] prod_slot;
    logic              cls_set;
    logic              abs_en;
    logic              ccmp_en;
    logic              div_init;
    logic              div_step;
    logic              commit;
  } cmd_t;

  typedef struct packed {
    logic room_nz;
    logic best_valid;
    logic gcmp_take;
    logic any_pick;
    logic both_pick;
    logic mul_done;
    logic out_free;
  } sts_t;

endpackage

[rtl/glbp_mul.sv]
// Shared multiplier: one 32 by 32 partial product per cycle, accumulated into the product; done marks it ready.
`timescale 1ns / 1ps
module glbp_mul (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [glbp_pkg::NUM_W-1:0]       a,
  input  logic [glbp_pkg::CTP_W-1:0]       b,
  output logic                             done,
  output logic [glbp_pkg::PROD_W-1:0]      prod
);

  logic [1:0]                      k_r, k_nxt;
  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [glbp_pkg::NUM_W-1:0]      a_r;
  logic [glbp_pkg::CTP_W-1:0]      b_r;
  logic [glbp_pkg::PROD_W-1:0]     acc_r;
  logic [31:0]                     a_part, b_part;
  logic [63:0]                     pp;
  logic [glbp_pkg::PROD_W-1:0]     pp_sh;

  always_comb begin
    a_part = k_r[1] ? {15'b0, a_r[48:32]} : a_r[31:0];
    b_part = k_r[0] ? {22'b0, b_r[41:32]} : b_r[31:0];
    pp     = 64'(a_part) * 64'(b_part);
    case (k_r)
      2'd0:    pp_sh = {27'b0, pp};
      2'd3:    pp_sh = {pp[26:0], 64'b0};
      default: pp_sh = {pp[58:0], 32'b0};
    endcase
  end

  always_comb begin
    k_nxt    = k_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      k_nxt    = 2'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      k_nxt = k_r + 2'd1;
      if (k_r == 2'd3) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= 2'd0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      k_r    <= k_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + pp_sh;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

[rtl/glbp_datapath.sv]
// Datapath: configuration, placement state, candidate tracking, compares and slot divider.
`timescale 1ns / 1ps
module glbp_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [glbp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [glbp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [glbp_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [glbp_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  glbp_pkg::cmd_t                      cmd,
  output glbp_pkg::sts_t                      sts
);

  logic [glbp_pkg::RATE_W-1:0]    rate_r  [glbp_pkg::CLASSES];
  logic [glbp_pkg::CAP_W-1:0]     cap_r   [glbp_pkg::CLASSES];
  logic [glbp_pkg::PIPES_W-1:0]   pipes_r [glbp_pkg::CLASSES];
  logic [glbp_pkg::PCOUNT_W-1:0]  pcount_r;

  logic [glbp_pkg::PLACED_W-1:0]  placed_r [glbp_pkg::CLASSES][glbp_pkg::GROUPS];
  logic [glbp_pkg::EDGE_W-1:0]    edges_r  [glbp_pkg::CLASSES][glbp_pkg::GROUPS];
  logic [glbp_pkg::EDGE_W-1:0]    total_r  [glbp_pkg::CLASSES];

  logic [glbp_pkg::VID_W-1:0]     vid_r;
  logic [glbp_pkg::COST_W-1:0]    cost_r;

  logic                           bv_r    [glbp_pkg::CLASSES];
  logic [glbp_pkg::GRP_W-1:0]     bg_r    [glbp_pkg::CLASSES];
  logic [glbp_pkg::NUM_W-1:0]     bnum_r  [glbp_pkg::CLASSES];
  logic [glbp_pkg::TP_W-1:0]      btp_r   [glbp_pkg::CLASSES];
  logic [glbp_pkg::ROOM_W-1:0]    broom_r [glbp_pkg::CLASSES];
  logic [glbp_pkg::CTP_W-1:0]     ctp_r   [glbp_pkg::CLASSES];

  logic [glbp_pkg::PROD_W-1:0]    prod_r [glbp_pkg::PROD_SLOTS];
  logic [glbp_pkg::PROD_W-1:0]    d1_r, d2_r;
  logic                           sel_cls_r;
  logic [glbp_pkg::PLACED_W-1:0]  dq_r;
  logic [glbp_pkg::CAP_W-1:0]     rem_r;

  logic                           out_valid_r;
  logic [glbp_pkg::OUT_DATA_W-1:0] out_data_r;

  logic                           ra_cls;
  logic [glbp_pkg::GRP_W-1:0]     ra_g;
  logic [glbp_pkg::PLACED_W-1:0]  rd_placed;
  logic [glbp_pkg::EDGE_W-1:0]    rd_edges;
  logic [glbp_pkg::PCOUNT_W-1:0]  pc_sat;
  logic [glbp_pkg::ROOM_W-1:0]    lim, room;
  logic [glbp_pkg::PIPE_W-1:0]    pipe;
  logic [glbp_pkg::TP_W-1:0]      tp_raw, tp;
  logic [glbp_pkg::NUM_W-1:0]     num;
  logic                           gcmp_take;
  logic [glbp_pkg::NUM_W-1:0]     mul_a;
  logic [glbp_pkg::CTP_W-1:0]     mul_b;
  logic                           mul_done;
  logic [glbp_pkg::PROD_W-1:0]    mul_prod;
  logic [glbp_pkg::PROD_W-1:0]    d1, d2;
  logic [glbp_pkg::CAP_W-1:0]     cap_sel;
  logic [glbp_pkg::CAP_W:0]       rem_sh;
  logic                           q_bit;
  logic                           fail;

  // One read address into the placement state: the scan position or the pick.
  always_comb begin
    ra_cls    = cmd.use_pick ? sel_cls_r : cmd.cls;
    ra_g      = cmd.use_pick ? bg_r[sel_cls_r] : cmd.g;
    rd_placed = placed_r[ra_cls][ra_g];
    rd_edges  = edges_r[ra_cls][ra_g];
    pc_sat    = (pcount_r > glbp_pkg::PCOUNT_MAX) ? glbp_pkg::PCOUNT_MAX : pcount_r;
    lim       = glbp_pkg::ROOM_W'(cap_r[ra_cls]) * glbp_pkg::ROOM_W'(pc_sat);
    room      = ({1'b0, rd_placed} >= lim) ? '0 : lim - {1'b0, rd_placed};
    pipe      = pipes_r[ra_cls][{1'b0, ra_g, 3'b000} +: glbp_pkg::PIPE_W];
    tp_raw    = glbp_pkg::TP_W'(rate_r[ra_cls]) * glbp_pkg::TP_W'(pipe);
    tp        = (tp_raw < glbp_pkg::TP_FLOOR) ? glbp_pkg::TP_FLOOR : tp_raw;
    num       = glbp_pkg::NUM_W'(rd_edges) + glbp_pkg::NUM_W'(cost_r);
    gcmp_take = (prod_r[0] < prod_r[1]) ||
                ((prod_r[0] == prod_r[1]) && (room > broom_r[ra_cls]));
  end

  always_comb begin
    case (cmd.mul_sel)
      glbp_pkg::MS_NUM_BTP: begin
        mul_a = num;
        mul_b = glbp_pkg::CTP_W'(btp_r[ra_cls]);
      end
      glbp_pkg::MS_BNUM_TP: begin
        mul_a = bnum_r[ra_cls];
        mul_b = glbp_pkg::CTP_W'(tp);
      end
      glbp_pkg::MS_DEC_ST: begin
        mul_a = glbp_pkg::NUM_W'(total_r[0]) + glbp_pkg::NUM_W'(cost_r);
        mul_b = ctp_r[1];
      end
      glbp_pkg::MS_SE_DT: begin
        mul_a = glbp_pkg::NUM_W'(total_r[1]);
        mul_b = ctp_r[0];
      end
      glbp_pkg::MS_DE_ST: begin
        mul_a = glbp_pkg::NUM_W'(total_r[0]);
        mul_b = ctp_r[1];
      end
      glbp_pkg::MS_SEC_DT: begin
        mul_a = glbp_pkg::NUM_W'(total_r[1]) + glbp_pkg::NUM_W'(cost_r);
        mul_b = ctp_r[0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  glbp_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_comb begin
    d1      = (prod_r[0] >= prod_r[1]) ? prod_r[0] - prod_r[1] : prod_r[1] - prod_r[0];
    d2      = (prod_r[2] >= prod_r[3]) ? prod_r[2] - prod_r[3] : prod_r[3] - prod_r[2];
    cap_sel = cap_r[sel_cls_r];
    rem_sh  = {rem_r, dq_r[glbp_pkg::PLACED_W-1]};
    q_bit   = rem_sh >= {1'b0, cap_sel};
    fail    = !bv_r[0] && !bv_r[1];
  end

  // Configuration and placement state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r[0]   <= 32'd256;
      rate_r[1]   <= 32'd256;
      cap_r[0]    <= 16'd1024;
      cap_r[1]    <= 16'd1024;
      pcount_r    <= 9'd1;
      pipes_r[0]  <= '0;
      pipes_r[1]  <= '0;
      for (int c = 0; c < glbp_pkg::CLASSES; c++) begin
        total_r[c] <= '0;
        for (int g = 0; g < glbp_pkg::GROUPS; g++) begin
          placed_r[c][g] <= '0;
          edges_r[c][g]  <= '0;
        end
      end
    end else begin
      if (cfg_we) begin
        unique case (glbp_pkg::cfg_reg_t'(cfg_addr))
          glbp_pkg::CFG_DENSE_RATE:   rate_r[0]  <= cfg_data[glbp_pkg::RATE_W-1:0];
          glbp_pkg::CFG_SPARSE_RATE:  rate_r[1]  <= cfg_data[glbp_pkg::RATE_W-1:0];
          glbp_pkg::CFG_DENSE_CAP:    cap_r[0]   <= cfg_data[glbp_pkg::CAP_W-1:0];
          glbp_pkg::CFG_SPARSE_CAP:   cap_r[1]   <= cfg_data[glbp_pkg::CAP_W-1:0];
          glbp_pkg::CFG_PART_COUNT:   pcount_r   <= cfg_data[glbp_pkg::PCOUNT_W-1:0];
          glbp_pkg::CFG_DENSE_PIPES:  pipes_r[0] <= cfg_data;
          glbp_pkg::CFG_SPARSE_PIPES: pipes_r[1] <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit && !fail) begin
        placed_r[ra_cls][ra_g] <= rd_placed + glbp_pkg::PLACED_W'(1);
        edges_r[ra_cls][ra_g]  <= rd_edges + glbp_pkg::EDGE_W'(cost_r);
        total_r[ra_cls]        <= total_r[ra_cls] + glbp_pkg::EDGE_W'(cost_r);
      end
    end
  end

  // Per-request working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r[0] <= 1'b0;
      bv_r[1] <= 1'b0;
    end else if (cmd.start_item) begin
      bv_r[0] <= 1'b0;
      bv_r[1] <= 1'b0;
    end else if (cmd.take) begin
      bv_r[ra_cls] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_item) begin
      vid_r    <= in_tdata[glbp_pkg::VID_W-1:0];
      cost_r   <= in_tdata[glbp_pkg::IN_DATA_W-1:glbp_pkg::VID_W];
      ctp_r[0] <= '0;
      ctp_r[1] <= '0;
    end else if (cmd.acc_tp) begin
      ctp_r[ra_cls] <= ctp_r[ra_cls] + glbp_pkg::CTP_W'(tp);
    end
    if (cmd.take) begin
      bg_r[ra_cls]    <= ra_g;
      bnum_r[ra_cls]  <= num;
      btp_r[ra_cls]   <= tp;
      broom_r[ra_cls] <= room;
    end
    if (cmd.prod_wr) begin
      prod_r[cmd.prod_slot] <= mul_prod;
    end
    if (cmd.abs_en) begin
      d1_r <= d1;
      d2_r <= d2;
    end
    if (cmd.cls_set) begin
      sel_cls_r <= !bv_r[0];
    end else if (cmd.ccmp_en) begin
      // Ties between the two balance figures go to the dense class.
      sel_cls_r <= !(d1_r <= d2_r);
    end
    if (cmd.div_init) begin
      dq_r  <= rd_placed;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? glbp_pkg::CAP_W'(rem_sh - {1'b0, cap_sel})
                     : rem_sh[glbp_pkg::CAP_W-1:0];
      dq_r  <= {dq_r[glbp_pkg::PLACED_W-2:0], q_bit};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (fail) begin
        out_data_r <= {3'b0, 1'b1, 8'd0, 3'd0, 1'b0, vid_r};
      end else begin
        out_data_r <= {3'b0, 1'b0, dq_r[glbp_pkg::PART_W-1:0], 1'b0, ra_g,
                       !sel_cls_r, vid_r};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    sts.room_nz    = room != '0;
    sts.best_valid = bv_r[ra_cls];
    sts.gcmp_take  = gcmp_take;
    sts.any_pick   = bv_r[0] || bv_r[1];
    sts.both_pick  = bv_r[0] && bv_r[1];
    sts.mul_done   = mul_done;
    sts.out_free   = !out_valid_r || out_tready;
  end

endmodule

[rtl/glbp_ctrl.sv]
// Controller: sequences the group scan, the class balance compare, the slot division and the commit.
`timescale 1ns / 1ps
module glbp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output glbp_pkg::cmd_t   cmd,
  input  glbp_pkg::sts_t   sts
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_GRP   = 15'b000000000000010,
    S_M1    = 15'b000000000000100,
    S_M2    = 15'b000000000001000,
    S_GCMP  = 15'b000000000010000,
    S_CLS   = 15'b000000000100000,
    S_CMA   = 15'b000000001000000,
    S_CMB   = 15'b000000010000000,
    S_CMC   = 15'b000000100000000,
    S_CMD   = 15'b000001000000000,
    S_ABS   = 15'b000010000000000,
    S_CCMP  = 15'b000100000000000,
    S_DINIT = 15'b001000000000000,
    S_DIV   = 15'b010000000000000,
    S_FIN   = 15'b100000000000000
  } state_t;

  state_t                          state_r, state_nxt;
  logic                            cls_r, cls_nxt;
  logic [glbp_pkg::GRP_W-1:0]      g_r, g_nxt;
  logic [glbp_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                            adv;

  always_comb begin
    state_nxt = state_r;
    cls_nxt   = cls_r;
    g_nxt     = g_r;
    cnt_nxt   = cnt_r;
    adv       = 1'b0;
    cmd       = '0;
    cmd.cls   = cls_r;
    cmd.g     = g_r;
    cmd.mul_sel = glbp_pkg::MS_NUM_BTP;
    in_tready = state_r == S_IDLE;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.start_item = 1'b1;
          cls_nxt        = 1'b0;
          g_nxt          = '0;
          state_nxt      = S_GRP;
        end
      end
      S_GRP: begin
        cmd.acc_tp = 1'b1;
        if (!sts.room_nz) begin
          adv = 1'b1;
        end else if (!sts.best_valid) begin
          cmd.take = 1'b1;
          adv      = 1'b1;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = glbp_pkg::MS_NUM_BTP;
          state_nxt     = S_M1;
        end
      end
      S_M1: begin
        if (sts.mul_done) begin
          cmd.prod_wr   = 1'b1;
          cmd.prod_slot = 2'd0;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = glbp_pkg::MS_BNUM_TP;
          state_nxt     = S_M2;
        end
      end
      S_M2: begin
        if (sts.mul_done) begin
          cmd.prod_wr   = 1'b1;
          cmd.prod_slot = 2'd1;
          state_nxt     = S_GCMP;
        end
      end
      S_GCMP: begin
        cmd.take = sts.gcmp_take;
        adv      = 1'b1;
      end
      S_CLS: begin
        cmd.cls_set = 1'b1;
        if (!sts.any_pick) begin
          state_nxt = S_FIN;
        end else if (sts.both_pick) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = glbp_pkg::MS_DEC_ST;
          state_nxt     = S_CMA;
        end else begin
          state_nxt = S_DINIT;
        end
      end
      S_CMA: begin
        if (sts.mul_done) begin
          cmd.prod_wr   = 1'b1;
          cmd.prod_slot = 2'd0;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = glbp_pkg::MS_SE_DT;
          state_nxt     = S_CMB;
        end
      end
      S_CMB: begin
        if (sts.mul_done) begin
          cmd.prod_wr   = 1'b1;
          cmd.prod_slot = 2'd1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = glbp_pkg::MS_DE_ST;
          state_nxt     = S_CMC;
        end
      end
      S_CMC: begin
        if (sts.mul_done) begin
          cmd.prod_wr   = 1'b1;
          cmd.prod_slot = 2'd2;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = glbp_pkg::MS_SEC_DT;
          state_nxt     = S_CMD;
        end
      end
      S_CMD: begin
        if (sts.mul_done) begin
          cmd.prod_wr   = 1'b1;
          cmd.prod_slot = 2'd3;
          state_nxt     = S_ABS;
        end
      end
      S_ABS: begin
        cmd.abs_en = 1'b1;
        state_nxt  = S_CCMP;
      end
      S_CCMP: begin
        cmd.ccmp_en = 1'b1;
        state_nxt   = S_DINIT;
      end
      S_DINIT: begin
        cmd.use_pick = 1'b1;
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + glbp_pkg::DIV_CNT_W'(1);
        if (cnt_r == glbp_pkg::DIV_CNT_W'(glbp_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.use_pick = 1'b1;
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Move to the next group, then to the sparse class, then to the class decision.
    if (adv) begin
      if (g_r == glbp_pkg::GRP_W'(glbp_pkg::GROUPS - 1)) begin
        g_nxt = '0;
        if (cls_r) begin
          state_nxt = S_CLS;
        end else begin
          cls_nxt   = 1'b1;
          state_nxt = S_GRP;
        end
      end else begin
        g_nxt     = g_r + glbp_pkg::GRP_W'(1);
        state_nxt = S_GRP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cls_r   <= 1'b0;
      g_r     <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cls_r   <= cls_nxt;
      g_r     <= g_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[rtl/greedy_load_balanced_placer.sv]
// Top level of the greedy load balanced placer: controller plus datapath, one request at a time.
// A group goes to the shared multiplier only when it has room and its class already has a best;
// the class step uses it only when both classes have room; the slot division follows the class step.
// A failed request skips the division; the result waits while the output stalls, and the next
// request is accepted in the cycle after the commit. Reset (rst_n, synchronous, active low) clears
// all placement counts and sums, loads the register defaults and empties the output register.
`timescale 1ns / 1ps
module greedy_load_balanced_placer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [glbp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [glbp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // vertex [23:0], indegree [47:24]
  input  logic [glbp_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // placed_vertex [23:0], dense flag [24], group_index [26:25], zero [27], partition_index [35:28],
  // failed [36], zero fill [39:37]
  output logic [glbp_pkg::OUT_DATA_W-1:0]     out_tdata
);

  glbp_pkg::cmd_t cmd;
  glbp_pkg::sts_t sts;

  glbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  glbp_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

[test/greedy_load_balanced_placer_tb.sv]
// Testbench of the greedy load balanced placer: directed and random stimulus checked against a predictor.
`timescale 1ns / 1ps
module greedy_load_balanced_placer_tb;

  typedef struct packed {
    logic [2:0]  fill;
    logic        failed;
    logic [7:0]  part;
    logic [2:0]  grp;
    logic        dense_cls;
    logic [23:0] vid;
  } placement_t;

  class placement_board;
    logic [31:0] rate [2];
    logic [15:0] cap [2];
    logic [8:0]  pcount;
    logic [63:0] pipes [2];
    logic [23:0] placed [2][4];
    logic [47:0] edges [2][4];
    logic [47:0] total [2];
    placement_t  pending [$];
    int          errors;

    function void clear();
      rate[0] = 256; rate[1] = 256; cap[0] = 1024; cap[1] = 1024;
      pcount = 1; pipes[0] = 0; pipes[1] = 0; total[0] = 0; total[1] = 0;
      for (int c = 0; c < 2; c++)
        for (int g = 0; g < 4; g++) begin
          placed[c][g] = 0; edges[c][g] = 0;
        end
      pending.delete(); errors = 0;
    endfunction

    function void write_reg(glbp_pkg::cfg_reg_t a, logic [63:0] d);
      case (a)
        glbp_pkg::CFG_DENSE_RATE:   rate[0] = d[31:0];
        glbp_pkg::CFG_SPARSE_RATE:  rate[1] = d[31:0];
        glbp_pkg::CFG_DENSE_CAP:    cap[0] = d[15:0];
        glbp_pkg::CFG_SPARSE_CAP:   cap[1] = d[15:0];
        glbp_pkg::CFG_PART_COUNT:   pcount = d[8:0];
        glbp_pkg::CFG_DENSE_PIPES:  pipes[0] = d;
        glbp_pkg::CFG_SPARSE_PIPES: pipes[1] = d;
        default: ;
      endcase
    endfunction

    function logic [63:0] throughput(int c, int g);
      logic [63:0] t;
      t = rate[c] * pipes[c][8*g +: 8];
      return (t < 256) ? 64'd256 : t;
    endfunction

    function logic [63:0] room(int c, int g);
      logic [63:0] lim;
      lim = cap[c] * ((pcount > 256) ? 64'd256 : 64'(pcount));
      return (placed[c][g] >= lim) ? 64'd0 : lim - placed[c][g];
    endfunction

    // Returns -1 when no group of the class has room.
    function int choose_group(int c, logic [23:0] cost);
      int best;
      logic [63:0] bnum, btp, broom, num, tp, rm;
      logic [127:0] lhs, rhs;
      best = -1; bnum = 0; btp = 1; broom = 0;
      for (int g = 0; g < 4; g++) begin
        rm = room(c, g);
        if (rm != 0) begin
          num = edges[c][g] + cost;
          tp = throughput(c, g);
          lhs = 128'(num) * btp;
          rhs = 128'(bnum) * tp;
          if (best < 0 || lhs < rhs || (lhs == rhs && rm > broom)) begin
            best = g; bnum = num; btp = tp; broom = rm;
          end
        end
      end
      return best;
    endfunction

    function void note_request(logic [23:0] vid, logic [23:0] cost);
      int dg, sg, c, g;
      logic [63:0] dt, st;
      logic [127:0] a, b, d_if, s_if;
      placement_t p;
      p = '0; p.vid = vid;
      dg = choose_group(0, cost); sg = choose_group(1, cost);
      if (dg < 0 && sg < 0) begin
        p.failed = 1;
        pending = {pending, p};
        return;
      end
      if (sg < 0) c = 0;
      else if (dg < 0) c = 1;
      else begin
        dt = 0; st = 0;
        for (int k = 0; k < 4; k++) begin
          dt += throughput(0, k); st += throughput(1, k);
        end
        a = 128'(64'(total[0]) + cost) * st; b = 128'(total[1]) * dt;
        d_if = (a > b) ? a - b : b - a;
        a = 128'(total[0]) * st; b = 128'(64'(total[1]) + cost) * dt;
        s_if = (a > b) ? a - b : b - a;
        c = (d_if <= s_if) ? 0 : 1;
      end
      g = (c == 0) ? dg : sg;
      p.dense_cls = (c == 0);
      p.grp = 3'(g);
      p.part = 8'(placed[c][g] / cap[c]);
      placed[c][g] += 1;
      edges[c][g] += cost;
      total[c] += cost;
      pending = {pending, p};
    endfunction

    function void check_result(placement_t got);
      placement_t exp_p;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_p = pending.pop_front();
      if (got !== exp_p) begin
        $display("%0t: mismatch expected vid %h dense %b grp %0d part %0d failed %b fill %b",
                 $time, exp_p.vid, exp_p.dense_cls, exp_p.grp, exp_p.part, exp_p.failed,
                 exp_p.fill);
        $display("%0t:          actual   vid %h dense %b grp %0d part %0d failed %b fill %b",
                 $time, got.vid, got.dense_cls, got.grp, got.part, got.failed, got.fill);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, cfg_we, in_tvalid, in_tready, out_tvalid, out_tready;
  logic [glbp_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [glbp_pkg::CFG_DATA_W-1:0] cfg_data;
  logic [glbp_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [glbp_pkg::OUT_DATA_W-1:0] out_tdata;
  placement_board board;
  bit   quiet;
  longint cycles;

  greedy_load_balanced_placer u_top (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: stalls in bursts, checks on each accepted result.
  initial begin
    int gap;
    out_tready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 13);
        out_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
      if (out_tvalid && out_tready) board.check_result(placement_t'(out_tdata));
    end
  end

  task automatic send(logic [23:0] vid, logic [23:0] cost);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {cost, vid};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_request(vid, cost);
  endtask

  task automatic write_reg(glbp_pkg::cfg_reg_t a, logic [63:0] d);
    cfg_we <= 1; cfg_addr <= a; cfg_data <= d;
    @(posedge clk);
    cfg_we <= 0;
    board.write_reg(a, d);
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // Sorted falling costs with a little disorder.
  task automatic run_batch(int n, logic [23:0] top);
    logic [23:0] c;
    c = top;
    for (int i = 0; i < n; i++) begin
      send(24'($urandom), ($urandom_range(0, 9) == 0) ? 24'($urandom) : c);
      c = c - ((c > 50) ? 24'($urandom_range(0, c / 20)) : 24'(c != 0));
    end
  endtask

  initial begin
    logic [63:0] v;
    board = new();
    board.clear();
    cycles = 0; quiet = 0;
    rst_n = 0; cfg_we = 0; cfg_addr = '0; cfg_data = '0; in_tvalid = 0; in_tdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: defaults, then field extremes and small caps that run out of room.
    send(24'hFFFFFF, 24'hFFFFFF);
    send(24'h000000, 24'h000000);
    send(24'hAAAAAA, 24'h555555);
    send(24'h555555, 24'hAAAAAA);
    drain();
    write_reg(glbp_pkg::CFG_DENSE_CAP, 64'd1);
    write_reg(glbp_pkg::CFG_SPARSE_CAP, 64'd2);
    write_reg(glbp_pkg::CFG_PART_COUNT, 64'd1);
    write_reg(glbp_pkg::CFG_DENSE_PIPES, 64'h00000000_01020304);
    write_reg(glbp_pkg::CFG_SPARSE_PIPES, 64'hFFFFFFFF_FF00FF80);
    write_reg(glbp_pkg::CFG_DENSE_RATE, 64'hFFFFFFFF);
    write_reg(glbp_pkg::CFG_SPARSE_RATE, 64'd0);
    for (int i = 0; i < 14; i++) send(24'($urandom), 24'(1000 - i * 50));
    drain();
    // Partition count zero fails everything; above 256 is clamped.
    write_reg(glbp_pkg::CFG_PART_COUNT, 64'd0);
    send(24'h123456, 24'd5);
    send(24'h654321, 24'd0);
    drain();
    write_reg(glbp_pkg::CFG_PART_COUNT, 64'h1FF);
    write_reg(glbp_pkg::CFG_DENSE_CAP, 64'd0);
    send(24'h000001, 24'd7);
    drain();

    // Random phases with fresh settings.
    for (int ph = 0; ph < 12; ph++) begin
      quiet = (ph >= 10);
      write_reg(glbp_pkg::CFG_DENSE_RATE,
                (ph % 4 == 0) ? 64'hFFFFFFFF : 64'($urandom_range(0, 2048)));
      write_reg(glbp_pkg::CFG_SPARSE_RATE, (ph % 3 == 0) ? 64'h0 : 64'($urandom));
      write_reg(glbp_pkg::CFG_DENSE_CAP, (ph == 5) ? 64'hFFFF : 64'($urandom_range(1, 6)));
      write_reg(glbp_pkg::CFG_SPARSE_CAP, (ph == 6) ? 64'h0 : 64'($urandom_range(1, 6)));
      write_reg(glbp_pkg::CFG_PART_COUNT, (ph == 7) ? 64'd256 : 64'($urandom_range(1, 8)));
      v = {$urandom, $urandom};
      write_reg(glbp_pkg::CFG_DENSE_PIPES, (ph == 2) ? 64'hFFFFFFFFFFFFFFFF : v);
      v = {$urandom, $urandom};
      write_reg(glbp_pkg::CFG_SPARSE_PIPES, (ph == 3) ? 64'h0 : v);
      run_batch(40, (ph == 1) ? 24'hFFFFFF : 24'($urandom_range(0, 100000)));
      drain();
    end

    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

[greedy_load_balanced_placer.f]
rtl/glbp_pkg.sv
rtl/glbp_mul.sv
rtl/glbp_datapath.sv
rtl/glbp_ctrl.sv
rtl/greedy_load_balanced_placer.sv
test/greedy_load_balanced_placer_tb.sv
